// ===== hw/rtl/lee_pkg.sv =====
// Shared constants, codes and controller/datapath struct types of the line editor.
// No dependencies; all other files but lee_ram refer to it by scoped names.
package lee_pkg;

    localparam int LINE_DEPTH = 63;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);

    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] ERASE_RESET  = 8'd35;
    localparam logic [CHAR_W-1:0] KILL_RESET   = 8'd64;

    localparam logic [CFG_IDX_W-1:0] REG_ERASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KILL  = 1'd1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic in_ready;
        logic edit;
        logic rd_clear;
        logic load_char;
        logic load_newline;
    } lee_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_valid;
        logic is_edit;
        logic flush_req;
        logic more_chars;
        logic slot_free;
    } lee_sts_t;

endpackage

// ===== hw/rtl/lee_if.sv =====
// Valid/ready stream interfaces for the character input and the edited line output.
// Depends on lee_pkg for the character width.
interface lee_char_if;
    logic                       valid;
    logic                       ready;
    logic [lee_pkg::CHAR_W-1:0] in_char;
    logic                       end_of_text;

    modport source (output valid, output in_char, output end_of_text, input ready);
    modport sink   (input valid, input in_char, input end_of_text, output ready);
endinterface

interface lee_line_if;
    logic                       valid;
    logic                       ready;
    logic [lee_pkg::CHAR_W-1:0] out_char;
    logic                       last;
    logic                       overflowed;

    modport source (output valid, output out_char, output last, output overflowed,
                    input ready);
    modport sink   (input valid, input out_char, input last, input overflowed,
                    output ready);
endinterface

// ===== hw/rtl/lee_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ===== hw/rtl/lee_ctrl.sv =====
// Controller state machine of the line editor: input acceptance and line flush sequencing.
// Depends on lee_pkg for the command and status structs.
module lee_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  lee_pkg::lee_sts_t sts,
    output lee_pkg::lee_cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_LOAD  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.in_valid)
                begin
                    cmd.edit = sts.is_edit;
                    if (sts.flush_req)
                    begin
                        cmd.rd_clear = 1'b1;
                        state_next   = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                // read address settles here, data shows in the next state
                if (sts.more_chars)
                begin
                    state_next = S_LOAD;
                end
                else if (sts.slot_free)
                begin
                    cmd.load_newline = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_LOAD:
            begin
                if (sts.slot_free)
                begin
                    cmd.load_char = 1'b1;
                    state_next    = S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/lee_dp.sv =====
// Datapath of the line editor: config registers, line buffer RAM, counters, output register.
// Depends on lee_pkg, lee_if and lee_ram.
module lee_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    lee_char_if.sink                            chars,
    lee_line_if.source                          lines,
    input  logic                                cfg_we,
    input  logic [lee_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lee_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  lee_pkg::lee_cmd_t                   cmd,
    output lee_pkg::lee_sts_t                   sts
);

    logic [lee_pkg::CHAR_W-1:0] erase_reg;
    logic [lee_pkg::CHAR_W-1:0] kill_reg;
    logic [lee_pkg::CNT_W-1:0]  fill_reg;
    logic [lee_pkg::CNT_W-1:0]  fill_next;
    logic                       started_reg;
    logic                       started_next;
    logic                       drop_reg;
    logic                       drop_next;
    logic [lee_pkg::CNT_W-1:0]  rd_idx_reg;
    logic                       out_valid_reg;
    logic [lee_pkg::CHAR_W-1:0] out_char_reg;
    logic                       out_last_reg;
    logic                       out_ovf_reg;

    logic                       ram_we;
    logic [lee_pkg::CHAR_W-1:0] ram_rdata;
    logic                       is_newline;

    assign is_newline = (chars.in_char == lee_pkg::NEWLINE_CODE);

    assign chars.ready    = cmd.in_ready;
    assign sts.in_valid   = chars.valid;
    assign sts.is_edit    = !chars.end_of_text && !is_newline;
    assign sts.flush_req  = chars.end_of_text ? started_reg : is_newline;
    assign sts.more_chars = (rd_idx_reg < fill_reg);
    assign sts.slot_free  = !out_valid_reg || lines.ready;

    assign lines.valid      = out_valid_reg;
    assign lines.out_char   = out_char_reg;
    assign lines.last       = out_last_reg;
    assign lines.overflowed = out_ovf_reg;

    // Erase wins over kill, append while there is room, else flag a drop; newline load clears all
    always_comb
    begin
        fill_next    = fill_reg;
        started_next = started_reg;
        drop_next    = drop_reg;
        ram_we       = 1'b0;
        if (cmd.edit)
        begin
            started_next = 1'b1;
            if (chars.in_char == erase_reg)
            begin
                if (fill_reg != '0)
                begin
                    fill_next = fill_reg - 1'b1;
                end
            end
            else if (chars.in_char == kill_reg)
            begin
                fill_next = '0;
                drop_next = 1'b0;
            end
            else if (fill_reg < lee_pkg::CNT_W'(lee_pkg::LINE_DEPTH))
            begin
                ram_we    = 1'b1;
                fill_next = fill_reg + 1'b1;
            end
            else
            begin
                drop_next = 1'b1;
            end
        end
        if (cmd.load_newline)
        begin
            fill_next    = '0;
            started_next = 1'b0;
            drop_next    = 1'b0;
        end
    end

    lee_ram #(
        .WIDTH (lee_pkg::CHAR_W),
        .DEPTH (lee_pkg::LINE_DEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[lee_pkg::ADDR_W-1:0]),
        .wdata (chars.in_char),
        .raddr (rd_idx_reg[lee_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            erase_reg     <= lee_pkg::ERASE_RESET;
            kill_reg      <= lee_pkg::KILL_RESET;
            fill_reg      <= '0;
            started_reg   <= 1'b0;
            drop_reg      <= 1'b0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == lee_pkg::REG_ERASE))
            begin
                erase_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == lee_pkg::REG_KILL))
            begin
                kill_reg <= cfg_data;
            end
            fill_reg    <= fill_next;
            started_reg <= started_next;
            drop_reg    <= drop_next;
            if (cmd.rd_clear)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.load_char)
            begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
            if (cmd.load_char || cmd.load_newline)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (lines.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.load_char)
        begin
            out_char_reg <= ram_rdata;
            out_last_reg <= 1'b0;
            out_ovf_reg  <= drop_reg;
        end
        else if (cmd.load_newline)
        begin
            out_char_reg <= lee_pkg::NEWLINE_CODE;
            out_last_reg <= 1'b1;
            out_ovf_reg  <= drop_reg;
        end
    end

endmodule

// ===== hw/rtl/line_editor_erase_kill_top.sv =====
// Top level of the line editor with erase and kill characters.
// Depends on lee_pkg, lee_if, lee_ctrl and lee_dp (which holds the lee_ram line buffer).
//
// Usage:
//   chars  - input stream, one character per beat (in_char, end_of_text).
//   lines  - output stream of the edited line, oldest character first, then a
//            newline (code 10) beat with last = 1. overflowed is the same on
//            every beat of one line and marks characters dropped for lack of room.
//   cfg_we / cfg_index / cfg_data - write erase_char (index 0) or kill_char
//            (index 1); write only while the block is idle.
// Input and flush:
//   Ordinary, erase and kill characters keep the controller idle and chars.ready high.
//   A newline, or end of text on a started line, starts a flush: each stored
//   character needs a RAM read step (S_FETCH) and an output load step (S_LOAD),
//   and the closing newline is loaded from S_FETCH once no characters remain.
//   The first output beat is loaded in S_LOAD after S_FETCH, or straight from
//   S_FETCH for an empty line.
//   The loop over the buffer in the controller, one RAM read port, sets this order.
// Reset:
//   rst_n (asynchronous, active low) empties the line, clears the overflow
//   flag and restores erase '#' and kill '@'. The buffer RAM is not cleared.
// Stall:
//   A held output beat stays in the output register; the flush waits on it.
//   Once the closing newline is loaded, new characters are accepted again
//   even if that newline has not been taken yet.
module line_editor_erase_kill_top (
    input  logic                            clk,
    input  logic                            rst_n,
    lee_char_if.sink                        chars,
    lee_line_if.source                      lines,
    input  logic                            cfg_we,
    input  logic [lee_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lee_pkg::CFG_DATA_W-1:0]  cfg_data
);

    lee_pkg::lee_cmd_t cmd;
    lee_pkg::lee_sts_t sts;

    // Sequence acceptance and the flush walk
    lee_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Hold the line, the config registers and the output beat
    lee_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars),
        .lines     (lines),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== hw/rtl/lee_checker.sv =====
// Port-level assertions for the line editor, bound to line_editor_erase_kill_top.
// Depends on lee_pkg for the newline code.
module lee_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       chars_ready,
    input logic                       lines_valid,
    input logic                       lines_ready,
    input logic [lee_pkg::CHAR_W-1:0] out_char,
    input logic                       last,
    input logic                       overflowed
);

    // A stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        lines_valid && !lines_ready |=> lines_valid && $stable(out_char)
            && $stable(last) && $stable(overflowed))
        else $error("output beat changed while stalled");

    // Newline code appears exactly on the closing beat
    a_last_newline: assert property (@(posedge clk) disable iff (!rst_n)
        lines_valid |-> ((out_char == lee_pkg::NEWLINE_CODE) == last))
        else $error("newline code and last flag disagree");

    // Input stays blocked while a line character is pending
    a_busy_flush: assert property (@(posedge clk) disable iff (!rst_n)
        lines_valid && !last |-> !chars_ready)
        else $error("input accepted during line flush");

    // Overflow flag stays constant across consecutive beats of one line
    a_ovf_line: assert property (@(posedge clk) disable iff (!rst_n)
        lines_valid && lines_ready && !last ##1 lines_valid
            |-> overflowed == $past(overflowed))
        else $error("overflowed changed within a line");

endmodule

bind line_editor_erase_kill_top lee_checker u_lee_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .chars_ready (chars.ready),
    .lines_valid (lines.valid),
    .lines_ready (lines.ready),
    .out_char    (lines.out_char),
    .last        (lines.last),
    .overflowed  (lines.overflowed)
);
